// ----- rtl/co2rat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2rat_pkg
// Word types and register codes shared by the CO2 rise alarm tracker.
// ----------------------------------------------------------------------------
package co2rat_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_TREND_RISING = 1'd1;

    localparam logic [15:0] RISE_THRESHOLD_RST       = 16'd200;
    localparam logic        REQUIRE_TREND_RISING_RST = 1'b1;

    localparam logic [7:0] RISE_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] co2_ppm;
        logic        armed;
        logic [31:0] arm_generation;
        logic [15:0] baseline_in;
        logic        reading_stale;
    } t_in_word;

    typedef struct packed {
        logic               deltas_valid;
        logic signed [15:0] window_delta;
        logic signed [15:0] base_delta;
        logic [7:0]         rise_count;
        logic               alert;
        logic [15:0]        alert_rise;
        logic               baseline_set;
        logic [15:0]        baseline_out;
    } t_out_word;

    // word handed from the window stage to the evaluation stage
    typedef struct packed {
        t_in_word    item;
        logic [15:0] oldest;
        logic        deltas_ok;
    } t_win_word;

endpackage

// ----- rtl/co2rat_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2rat_window
// Ring window of recent readings and the input stage register. On accept
// the reading is written and the oldest entry for this word is read out.
// ----------------------------------------------------------------------------
module co2rat_window #(
    parameter int WINDOW_READINGS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  co2rat_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output co2rat_pkg::t_win_word o_word
);
    import co2rat_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_READINGS);
    localparam int FILL_W = $clog2(WINDOW_READINGS + 1);

    logic [15:0]       r_store [WINDOW_READINGS];
    logic [IDX_W-1:0]  r_wp;
    logic [IDX_W-1:0]  n_wp;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [IDX_W-1:0]  rd_idx;
    logic              r_valid;
    t_win_word         r_word;
    logic              accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_wp   = (r_wp == IDX_W'(WINDOW_READINGS - 1)) ? '0 : r_wp + 1'b1;
        n_fill = (r_fill == FILL_W'(WINDOW_READINGS)) ? r_fill : r_fill + 1'b1;
        // once full the oldest entry is the one overwritten next; before that it is entry 0
        rd_idx = (n_fill == FILL_W'(WINDOW_READINGS)) ? n_wp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wp    <= n_wp;
                r_fill  <= n_fill;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // read address never equals the write address once two readings are held
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[r_wp]    <= i_data.co2_ppm;
            r_word.item      <= i_data;
            r_word.oldest    <= r_store[rd_idx];
            r_word.deltas_ok <= (n_fill >= FILL_W'(2));
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/co2rat_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2rat_eval
// Deltas, baseline capture, rise qualification and alert, with the tracking
// state and the result register.
// ----------------------------------------------------------------------------
module co2rat_eval (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  co2rat_pkg::t_win_word i_word,
    input  logic [15:0]           i_rise_threshold,
    input  logic                  i_require_trend,
    output logic                  o_valid,
    input  logic                  i_stall,
    output co2rat_pkg::t_out_word o_data
);
    import co2rat_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] res;
        if (v[16] != v[15]) begin
            res = v[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    logic [31:0]        r_seen_gen;
    logic [7:0]         r_consec;
    logic [7:0]         n_consec;
    logic               r_alerted;
    logic               n_alerted;
    logic               r_out_v;
    t_out_word          r_out;
    t_out_word          n_out;
    logic               take;
    logic               gen_change;
    logic               capture;
    logic [15:0]        base;
    logic signed [16:0] since;
    logic signed [16:0] wraw;
    logic signed [15:0] wsat;
    logic               trig;
    logic [7:0]         consec_a;
    logic               alerted_a;
    logic               alert;

    assign o_stall = r_out_v && i_stall;
    assign take    = i_valid && !o_stall;

    always_comb begin
        gen_change = (i_word.item.arm_generation != r_seen_gen);
        alerted_a  = gen_change ? 1'b0 : r_alerted;
        capture    = i_word.item.armed && (i_word.item.baseline_in == 16'd0)
                     && (i_word.item.co2_ppm != 16'd0);
        consec_a   = (gen_change || capture) ? 8'd0 : r_consec;
        base       = capture ? i_word.item.co2_ppm : i_word.item.baseline_in;
        since      = $signed({1'b0, i_word.item.co2_ppm}) - $signed({1'b0, base});
        wraw       = $signed({1'b0, i_word.item.co2_ppm}) - $signed({1'b0, i_word.oldest});
        wsat       = sat16(wraw);
        trig       = i_word.item.armed && !i_word.item.reading_stale
                     && (since >= $signed({1'b0, i_rise_threshold}))
                     && !(i_require_trend && (wsat[15] || wsat == 16'sd0));

        n_consec  = consec_a;
        n_alerted = alerted_a;
        alert     = 1'b0;
        if (i_word.deltas_ok) begin
            if (trig) begin
                n_consec  = (consec_a == RISE_COUNT_MAX) ? consec_a : consec_a + 8'd1;
                alert     = !alerted_a && (n_consec >= 8'd2);
                n_alerted = alerted_a || alert;
            end else begin
                n_consec  = 8'd0;
                n_alerted = i_word.item.armed ? alerted_a : 1'b0;
            end
        end

        n_out.deltas_valid = i_word.deltas_ok;
        n_out.window_delta = i_word.deltas_ok ? wsat : 16'sd0;
        n_out.base_delta   = i_word.deltas_ok ? sat16(since) : 16'sd0;
        n_out.rise_count   = n_consec;
        n_out.alert        = alert;
        n_out.alert_rise   = alert ? since[15:0] : 16'd0;
        n_out.baseline_set = capture;
        n_out.baseline_out = capture ? i_word.item.co2_ppm : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_gen <= '0;
            r_consec   <= '0;
            r_alerted  <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (take) begin
                r_seen_gen <= i_word.item.arm_generation;
                r_consec   <= n_consec;
                r_alerted  <= n_alerted;
                r_out_v    <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ----- rtl/co2_rise_alarm_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_rise_alarm_tracker
// CO2 rise alarm tracker: ring window deltas, baseline capture and a
// once-per-arming rise alert, one reading per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one reading word per clock unless stalled and returns one result
// word for each, in order. The accepting edge writes the ring window and
// registers the oldest entry in the window stage; the evaluation stage then
// loads both saturated deltas, the baseline capture and the rise/alert
// update formed against the tracking state into the output register. With
// no stall downstream the throughput is one word every cycle; a stall at the
// output backs up through the two stage registers. Configuration writes
// must go in while no word is in flight, which the block does not enforce.
module co2_rise_alarm_tracker #(
    parameter int WINDOW_READINGS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  co2rat_pkg::t_in_word                 i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output co2rat_pkg::t_out_word                o_data,
    input  logic                                 i_cfg_we,
    input  logic [co2rat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [co2rat_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import co2rat_pkg::*;

    logic [15:0] r_rise_threshold;
    logic        r_require_trend;
    logic        win_valid;
    logic        eval_stall;
    t_win_word   win_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_threshold <= RISE_THRESHOLD_RST;
            r_require_trend  <= REQUIRE_TREND_RISING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RISE_THRESHOLD:       r_rise_threshold <= i_cfg_data[15:0];
                REG_REQUIRE_TREND_RISING: r_require_trend  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    co2rat_window #(
        .WINDOW_READINGS(WINDOW_READINGS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (win_valid),
        .i_stall (eval_stall),
        .o_word  (win_word)
    );

    co2rat_eval u_eval (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (win_valid),
        .o_stall          (eval_stall),
        .i_word           (win_word),
        .i_rise_threshold (r_rise_threshold),
        .i_require_trend  (r_require_trend),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data           (o_data)
    );

`ifndef SYNTHESIS
    // an alert needs at least two qualifying readings in a row
    a_alert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.alert) |-> (o_data.rise_count >= 8'd2))
        else $error("alert with rise_count below two");

    // a captured baseline is never zero
    a_capture_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.baseline_set) |-> (o_data.baseline_out != 16'd0))
        else $error("baseline captured as zero");

    // no deltas and no alert before the window holds two readings
    a_quiet_unfilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.deltas_valid) |->
            (!o_data.alert && o_data.window_delta == 16'sd0
             && o_data.base_delta == 16'sd0))
        else $error("deltas or alert reported with window unfilled");
`endif

endmodule
